>>> rtl/tilt_pid_balance_controller_top_assert.svh
// Assertion macros shared by the checker of the tilt balance controller.
// Depends on nothing; the user passes clock, reset and the expressions.
`ifndef TILT_PID_BALANCE_CONTROLLER_TOP_ASSERT_SVH
`define TILT_PID_BALANCE_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define TPBC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tpbc assertion failed");

// Next-cycle implication, disabled while reset is low.
`define TPBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tpbc assertion failed");

`endif

>>> rtl/tpbc_pkg.sv
// Package of the tilt balance controller: types, register indexes, constants.
// No dependencies.
`timescale 1ns / 1ps

package tpbc_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_GAIN_PROP  = 2'd0;
    localparam logic [1:0] CFG_GAIN_INTEG = 2'd1;
    localparam logic [1:0] CFG_GAIN_DERIV = 2'd2;
    localparam logic [1:0] CFG_TILT_LIMIT = 2'd3;

    // Register reset values
    localparam logic [15:0] GAIN_PROP_RST  = 16'd256;
    localparam logic [15:0] GAIN_INTEG_RST = 16'd51;
    localparam logic [15:0] GAIN_DERIV_RST = 16'd51;
    localparam logic [8:0]  TILT_LIMIT_RST = 9'd25;

    // Integral saturation bounds (24-bit signed)
    localparam logic signed [23:0] INTEG_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] INTEG_MIN = -24'sh800000;

    // Drive clamp
    localparam logic signed [7:0] DRIVE_MAX = 8'sd100;
    localparam logic signed [7:0] DRIVE_MIN = -8'sd100;

    typedef enum logic [1:0] {
        PHASE_NEG  = 2'd0,
        PHASE_POS  = 2'd1,
        PHASE_ZERO = 2'd2
    } t_phase;

    typedef struct packed {
        logic [15:0] gain_prop;
        logic [15:0] gain_integ;
        logic [15:0] gain_deriv;
        logic [8:0]  tilt_limit;
    } t_cfg;

    typedef struct packed {
        logic signed [7:0] drive;
        logic              halted;
    } t_result;

endpackage

>>> rtl/tilt_pid_balance_controller_top.sv
// Tilt balance controller top level: stream ports, input and result registers.
// An accepted beat goes from the input register into the result register.
// One beat per cycle unless stalled; PID update is one pass between registers.
// A stalled result register holds the input stage, which takes one more beat.
// Reset (i_rst_n low, synchronous) restores gains, clears PID state and fault.
// Depends on tpbc_pkg, tpbc_cfg_regs and tpbc_pid_core.
`timescale 1ns / 1ps

module tilt_pid_balance_controller_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] angle
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] drive
    output logic [0:0]  o_m_axis_tuser,   // [0] halted
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);
    import tpbc_pkg::*;

    t_cfg               w_cfg;
    t_result            w_result;

    logic               r_in_valid;
    logic signed [15:0] r_angle;
    logic               r_out_valid;
    logic [7:0]         r_drive;
    logic               r_halted;

    logic               w_in_accept;
    logic               w_advance;
    logic               w_step;

    // Result register frees up when empty or being drained this cycle
    assign w_advance       = !r_out_valid || i_m_axis_tready;
    assign w_step          = r_in_valid && w_advance;
    // Input stage takes a new beat when empty or moving forward
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_in_accept     = i_s_axis_tvalid && o_s_axis_tready;

    tpbc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // PID state advances only when its beat moves into the result register
    tpbc_pid_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_angle  (r_angle),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_angle <= $signed(i_s_axis_tdata);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_drive  <= w_result.drive;
            r_halted <= w_result.halted;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_drive;
    assign o_m_axis_tuser  = r_halted;

endmodule

>>> rtl/tpbc_cfg_regs.sv
// Configuration register file of the tilt balance controller.
// Depends on tpbc_pkg.
`timescale 1ns / 1ps

module tpbc_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_wdata,
    output tpbc_pkg::t_cfg      o_cfg
);
    import tpbc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_prop  <= GAIN_PROP_RST;
            r_cfg.gain_integ <= GAIN_INTEG_RST;
            r_cfg.gain_deriv <= GAIN_DERIV_RST;
            r_cfg.tilt_limit <= TILT_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GAIN_PROP:  r_cfg.gain_prop  <= i_cfg_wdata;
                CFG_GAIN_INTEG: r_cfg.gain_integ <= i_cfg_wdata;
                CFG_GAIN_DERIV: r_cfg.gain_deriv <= i_cfg_wdata;
                CFG_TILT_LIMIT: r_cfg.tilt_limit <= i_cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/tpbc_pid_core.sv
// PID core: fault latch, sign-phase machine, integral/derivative state and
// the single-pass drive computation with Q8.8 gains. Depends on tpbc_pkg.
`timescale 1ns / 1ps

module tpbc_pid_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic signed [15:0]   i_angle,
    input  tpbc_pkg::t_cfg       i_cfg,
    output tpbc_pkg::t_result    o_result
);
    import tpbc_pkg::*;

    t_phase             r_phase, n_phase;
    logic signed [23:0] r_integ, n_integ;
    logic signed [15:0] r_prev,  n_prev;
    logic               r_fault, n_fault;

    logic [16:0]        w_mag;
    logic               w_over;
    logic               w_clear;
    logic signed [23:0] w_base;
    logic signed [24:0] w_sum;
    logic signed [23:0] w_integ_sat;
    logic signed [16:0] w_deriv;
    logic signed [32:0] w_pp;
    logic signed [40:0] w_pi;
    logic signed [33:0] w_pd;
    logic signed [42:0] w_acc;
    logic signed [42:0] w_adj;
    logic signed [34:0] w_q;
    logic signed [7:0]  w_drive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PHASE_ZERO;
            r_integ <= '0;
            r_prev  <= '0;
            r_fault <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_integ <= n_integ;
            r_prev  <= n_prev;
            r_fault <= n_fault;
        end
    end

    // Magnitude and limit check; -32768 gives 32768, always past the limit
    assign w_mag  = i_angle[15] ? (17'd0 - {i_angle[15], i_angle}) : {1'b0, i_angle};
    assign w_over = w_mag > {8'd0, i_cfg.tilt_limit};

    // Integral clear on positive-to-negative move or on leaving the zero phase
    always_comb begin
        case (r_phase)
            PHASE_POS: w_clear = i_angle[15];
            PHASE_NEG: w_clear = 1'b0;
            default:   w_clear = 1'b1;
        endcase
    end

    assign w_base = w_clear ? 24'sd0 : r_integ;
    assign w_sum  = {w_base[23], w_base} + {{9{i_angle[15]}}, i_angle};

    always_comb begin
        if (w_sum[24] != w_sum[23]) begin
            w_integ_sat = w_sum[24] ? INTEG_MIN : INTEG_MAX;
        end else begin
            w_integ_sat = w_sum[23:0];
        end
    end

    assign w_deriv = {i_angle[15], i_angle} - {r_prev[15], r_prev};

    // Three independent gain products, summed once
    assign w_pp  = $signed({1'b0, i_cfg.gain_prop})  * i_angle;
    assign w_pi  = $signed({1'b0, i_cfg.gain_integ}) * w_integ_sat;
    assign w_pd  = $signed({1'b0, i_cfg.gain_deriv}) * w_deriv;
    assign w_acc = {{10{w_pp[32]}}, w_pp} + {{2{w_pi[40]}}, w_pi}
                 + {{9{w_pd[33]}}, w_pd};

    // Divide by 256 truncating toward zero
    assign w_adj = w_acc + (w_acc[42] ? 43'sd255 : 43'sd0);
    assign w_q   = w_adj[42:8];

    always_comb begin
        if (w_q > 35'sd100) begin
            w_drive = DRIVE_MAX;
        end else if (w_q < -35'sd100) begin
            w_drive = DRIVE_MIN;
        end else begin
            w_drive = w_q[7:0];
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_integ = r_integ;
        n_prev  = r_prev;
        n_fault = r_fault;
        o_result.drive  = 8'sd0;
        o_result.halted = 1'b0;
        if (r_fault || w_over) begin
            n_fault         = 1'b1;
            o_result.halted = 1'b1;
        end else if (i_angle == 16'sd0) begin
            n_phase = PHASE_ZERO;
        end else begin
            n_phase        = i_angle[15] ? PHASE_NEG : PHASE_POS;
            n_integ        = w_integ_sat;
            n_prev         = i_angle;
            o_result.drive = w_drive;
        end
    end

endmodule

>>> rtl/tpbc_checker.sv
// Port-level checker for the tilt balance controller, bound to the top level.
// Depends on tilt_pid_balance_controller_top_assert.svh.
`timescale 1ns / 1ps
`include "tilt_pid_balance_controller_top_assert.svh"

module tpbc_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [7:0]  i_m_axis_tdata,
    input logic [0:0]  i_m_axis_tuser
);

    logic              r_seen_halt;
    logic signed [7:0] w_drive;
    logic              w_halt;
    logic              w_in_range;
    logic              w_stall;
    logic [8:0]        w_beat;

    assign w_drive    = $signed(i_m_axis_tdata);
    assign w_halt     = i_m_axis_tuser[0];
    assign w_in_range = (w_drive <= 8'sd100) && (w_drive >= -8'sd100);
    assign w_stall    = i_m_axis_tvalid && !i_m_axis_tready;
    assign w_beat     = {i_m_axis_tuser, i_m_axis_tdata};

    // Remembers that a halted beat went out; the fault latch holds till reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_halt <= 1'b0;
        end else if (i_m_axis_tvalid && i_m_axis_tready && w_halt) begin
            r_seen_halt <= 1'b1;
        end
    end

    `TPBC_ASSERT_IMPLY(a_halt_zero_drive, i_clk, i_rst_n, i_m_axis_tvalid && w_halt, w_drive == 8'sd0)
    `TPBC_ASSERT_IMPLY(a_drive_range, i_clk, i_rst_n, i_m_axis_tvalid, w_in_range)
    `TPBC_ASSERT_IMPLY(a_halt_sticky, i_clk, i_rst_n, i_m_axis_tvalid && r_seen_halt, w_halt)
    `TPBC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_stall, i_m_axis_tvalid && $stable(w_beat))

endmodule

bind tilt_pid_balance_controller_top tpbc_port_checker u_tpbc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tuser  (o_m_axis_tuser)
);

>>> tb/sv/tpbc_checker.sv
// Checker for the tilt balance controller: watches the stream and config ports,
// predicts every drive beat and compares it against the result stream.
// Depends on tpbc_pkg.
`timescale 1ns / 1ps

module tpbc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] angle
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,   // [7:0] drive
    input  logic [0:0]  i_m_tuser,   // [0] halted
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending
);
    import tpbc_pkg::*;

    // Shadow copy of the registers and the controller state
    t_cfg    cfg_q;
    t_phase  phase_q;
    int      integ_q;
    int      prev_q;
    logic    fault_q;

    t_result drive_expect_q[$];
    int      fail_cnt = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_result pid_predict(input logic signed [15:0] ang_in);
        int      ang;
        int      mag;
        int      deriv;
        longint  gp;
        longint  gi;
        longint  gd;
        longint  sum;
        longint  acc;
        longint  quo;
        t_phase  next_phase;
        logic    clr;
        t_result res;

        ang = int'(ang_in);
        mag = (ang < 0) ? -ang : ang;
        if (!fault_q && mag > int'(cfg_q.tilt_limit))
            fault_q = 1'b1;

        res.drive  = '0;
        res.halted = fault_q;
        if (fault_q)
            return res;

        if (ang == 0) begin
            phase_q = PHASE_ZERO;
            return res;
        end

        // pos->neg and leaving zero clear the integral; neg->pos keeps it
        next_phase = (ang < 0) ? PHASE_NEG : PHASE_POS;
        if (phase_q == PHASE_POS)
            clr = (next_phase == PHASE_NEG);
        else
            clr = (phase_q != PHASE_NEG);
        phase_q = next_phase;
        if (clr)
            integ_q = 0;

        sum = longint'(integ_q) + longint'(ang);
        if (sum > longint'(INTEG_MAX)) sum = longint'(INTEG_MAX);
        if (sum < longint'(INTEG_MIN)) sum = longint'(INTEG_MIN);
        integ_q = int'(sum);

        deriv  = ang - prev_q;
        prev_q = ang;

        gp  = longint'(cfg_q.gain_prop);
        gi  = longint'(cfg_q.gain_integ);
        gd  = longint'(cfg_q.gain_deriv);
        acc = gp * ang + gi * integ_q + gd * deriv;
        quo = acc / 256;    // truncates toward zero
        if (quo > longint'(DRIVE_MAX)) quo = longint'(DRIVE_MAX);
        if (quo < longint'(DRIVE_MIN)) quo = longint'(DRIVE_MIN);
        res.drive = quo[7:0];
        return res;
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_result want;
        if (!i_rst_n) begin
            cfg_q.gain_prop  = GAIN_PROP_RST;
            cfg_q.gain_integ = GAIN_INTEG_RST;
            cfg_q.gain_deriv = GAIN_DERIV_RST;
            cfg_q.tilt_limit = TILT_LIMIT_RST;
            phase_q = PHASE_ZERO;
            integ_q = 0;
            prev_q  = 0;
            fault_q = 1'b0;
            drive_expect_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GAIN_PROP:  cfg_q.gain_prop  = i_cfg_wdata;
                    CFG_GAIN_INTEG: cfg_q.gain_integ = i_cfg_wdata;
                    CFG_GAIN_DERIV: cfg_q.gain_deriv = i_cfg_wdata;
                    CFG_TILT_LIMIT: cfg_q.tilt_limit = i_cfg_wdata[8:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                drive_expect_q.push_back(pid_predict(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                if (drive_expect_q.size() == 0) begin
                    $error("result beat with no prediction pending: drive %0d halted %0b",
                           $signed(i_m_tdata), i_m_tuser[0]);
                    fail_cnt++;
                end else begin
                    want = drive_expect_q.pop_front();
                    if ($signed(i_m_tdata) !== want.drive) begin
                        $error("drive mismatch: expected %0d, actual %0d",
                               want.drive, $signed(i_m_tdata));
                        fail_cnt++;
                    end
                    if (i_m_tuser[0] !== want.halted) begin
                        $error("halted mismatch: expected %0b, actual %0b",
                               want.halted, i_m_tuser[0]);
                        fail_cnt++;
                    end
                end
            end
        end
        o_pending    <= drive_expect_q.size();
        o_fail_count <= fail_cnt;
    end

endmodule

>>> tb/sv/testbench.sv
// Top of the tilt balance controller testbench: clock, reset, stimulus, verdict.
// Depends on tpbc_pkg, tilt_pid_balance_controller_top and tpbc_checker.
`timescale 1ns / 1ps

module testbench;
    import tpbc_pkg::*;

    localparam int ITEMS_PER_SETTING = 100;   // random beats per register setting
    localparam int SETTINGS_PER_MODE = 4;
    localparam int SAT_RUN           = 90;    // long same-sign run at the widest limit
    localparam int HOLD_CYCLES       = 60;    // long receiver hold-off
    localparam int DIR_N             = 17;

    // Directed angles under reset gains and the reset limit of 25:
    // phase walk (zero->pos, pos->neg clear, neg->pos keep), zero runs,
    // leaving zero into both signs, and both limit boundaries without a fault.
    localparam int DIRECTED [DIR_N] = '{5, 10, -3, -8, 7, 12, 0, 0, 4, -4,
                                        25, -25, 25, 1, -1, 0, -25};

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = CFG_GAIN_PROP;
    logic [15:0] cfg_wdata = '0;

    int   fail_count;
    int   pending;

    // Stimulus knobs; the receiver ones change only by NBA so the sink
    // process always samples them race free.
    int   send_idle_pct = 30;
    int   recv_idle_pct = 60;
    logic hold_armed    = 1'b0;
    int   cur_limit     = int'(TILT_LIMIT_RST);
    logic run_neg       = 1'b0;

    tilt_pid_balance_controller_top i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata)
    );

    tpbc_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Result sink: random back-pressure, plus a long hold-off when armed.
    // The hold-off is counted here so the sender keeps pushing beats and
    // the block has to fill up and drop s_tready.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_armed) begin
                hold_left = HOLD_CYCLES;
                hold_armed <= 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Offer one angle beat, with an optional idle gap first; returns at the
    // edge that accepted it, s_tvalid still high.
    task automatic send_angle(input logic signed [15:0] ang);
        int gap;
        gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ang;
        do @(posedge clk); while (!s_tready);
    endtask

    // Stop sending and wait until every predicted beat has come back, then
    // let the two pipeline stages settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // Write all four registers on back-to-back edges; only call while idle.
    task automatic load_config(input logic [15:0] gp, input logic [15:0] gi,
                               input logic [15:0] gd, input logic [8:0] lim);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_GAIN_PROP;
        cfg_wdata <= gp;
        @(posedge clk);
        cfg_index <= CFG_GAIN_INTEG;
        cfg_wdata <= gi;
        @(posedge clk);
        cfg_index <= CFG_GAIN_DERIV;
        cfg_wdata <= gd;
        @(posedge clk);
        cfg_index <= CFG_TILT_LIMIT;
        cfg_wdata <= {7'b0, lim};
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_limit = int'(lim);
    endtask

    // Setting k rotates through the corners: small gains, all-ones gains with
    // the widest limit, zero gains, a zero limit (only zero angles legal),
    // and mixed gains with any limit.
    task automatic pick_setting(input int k);
        case (k % 5)
            0: load_config(16'($urandom_range(0, 768)), 16'($urandom_range(0, 768)),
                           16'($urandom_range(0, 768)), 9'($urandom_range(1, 360)));
            1: load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 9'd511);
            2: load_config(16'h0000, 16'h0000, 16'h0000, 9'd360);
            3: load_config(16'($urandom), 16'($urandom), 16'($urandom), 9'd0);
            default: load_config(16'($urandom_range(0, 1024)), 16'h0000, 16'($urandom),
                                 9'($urandom_range(0, 511)));
        endcase
    endtask

    // Angles stay inside the limit: the fault latch only clears on reset,
    // so tripping it is saved for the very end. Sign runs flip now and then
    // to walk the phase machine; zeros, +-1 and +-limit show up often.
    function automatic logic signed [15:0] next_angle();
        int r;
        int mag;
        if (cur_limit == 0)
            return '0;
        if ($urandom_range(0, 99) < 20)
            run_neg = ~run_neg;
        r = $urandom_range(0, 99);
        if (r < 10)      mag = 0;
        else if (r < 20) mag = cur_limit;
        else if (r < 25) mag = 1;
        else             mag = $urandom_range(1, cur_limit);
        return 16'(run_neg ? -mag : mag);
    endfunction

    initial begin : stimulus
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed beats under reset values
        foreach (DIRECTED[i])
            send_angle(16'(DIRECTED[i]));
        wait_idle();

        // random part: three idle mixes, several register settings each
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin send_idle_pct = 30; recv_idle_pct <= 60; end
                1: begin send_idle_pct = 60; recv_idle_pct <= 30; end
                default: begin send_idle_pct = 0; recv_idle_pct <= 0; end
            endcase
            for (int j = 0; j < SETTINGS_PER_MODE; j++) begin
                pick_setting(mode * SETTINGS_PER_MODE + j);
                for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
                    if (n == 40)
                        hold_armed <= 1'b1;   // sink stalls, sender keeps going
                    if (n == 80)
                        wait_idle();          // sender drains everything first
                    send_angle(next_angle());
                end
                wait_idle();
            end
        end

        // Long same-sign runs at the widest limit, no idling: the integral
        // builds up, then pos->neg clears it and a negative run builds down.
        load_config(GAIN_PROP_RST, GAIN_INTEG_RST, GAIN_DERIV_RST, 9'd511);
        for (int n = 0; n < SAT_RUN; n++)
            send_angle(16'($urandom_range(490, 511)));
        for (int n = 0; n < SAT_RUN; n++)
            send_angle(16'(-int'($urandom_range(490, 511))));
        wait_idle();

        // Fault: -32768 always trips the latch, even at the widest limit;
        // everything after it reads back as halted with zero drive.
        load_config(16'($urandom_range(0, 768)), 16'($urandom_range(0, 768)),
                    16'($urandom_range(0, 768)), 9'd511);
        for (int n = 0; n < 5; n++)
            send_angle(next_angle());
        send_angle(16'sh8000);
        send_angle(16'sh7FFF);
        send_angle(16'sd512);
        send_angle(16'sd0);
        send_angle(-16'sd1);
        send_angle(16'sd300);
        wait_idle();
        repeat (10) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
